/* hw/rtl/rau_pkg.sv */
// Shared types and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    // Operation codes carried in the input transaction's tuser.
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_RED = 3'd4
    } op_t;

    // Sideband that travels with every item through the pipeline.
    typedef struct packed {
        logic zero;   // result is forced to 0/1
        logic neg;    // result is negative
    } side_t;

endpackage
`default_nettype wire

/* hw/rtl/rau_front.sv */
// Front end: operand split, cross products and numerator combination (three stages).
`default_nettype none
module rau_front #(
    parameter int WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire logic [2:0]             op,
    input  wire logic [WIDTH-1:0]       x_num,
    input  wire logic [WIDTH-1:0]       x_den,
    input  wire logic [WIDTH-1:0]       y_num,
    input  wire logic [WIDTH-1:0]       y_den,
    output logic                        out_valid,
    output logic [2*WIDTH-1:0]          out_n,
    output logic [2*WIDTH-1:0]          out_d,
    output rau_pkg::side_t              out_side
);
    localparam int L = 2 * WIDTH;

    logic [WIDTH-1:0] mxn, mxd, myn, myd;
    logic             sxn, sxd, syn, syd;

    // Stage 1: selected multiplier operands
    logic             v1_reg;
    logic [WIDTH-1:0] a1_reg, b1_reg, a2_reg, b2_reg, a3_reg, b3_reg;
    logic             s1_reg, s2_reg, sd_reg;
    logic [WIDTH-1:0] a1_next, b1_next, a2_next, b2_next, a3_next, b3_next;
    logic             s1_next, s2_next, sd_next;

    // Stage 2: products
    logic             v2_reg;
    logic [L-1:0]     p1_reg, p2_reg, pd_reg;
    logic             t1_reg, t2_reg, td_reg;

    // Stage 3: combined numerator
    logic             v3_reg;
    logic [L-1:0]     n3_reg, d3_reg;
    rau_pkg::side_t   side3_reg;
    logic [L-1:0]     n3_next;
    logic             sn3;

    assign sxn = x_num[WIDTH-1];
    assign sxd = x_den[WIDTH-1];
    assign syn = y_num[WIDTH-1];
    assign syd = y_den[WIDTH-1];
    // The most negative value negates to itself, which read unsigned is 2^(WIDTH-1).
    assign mxn = sxn ? (~x_num + {{(WIDTH-1){1'b0}}, 1'b1}) : x_num;
    assign mxd = sxd ? (~x_den + {{(WIDTH-1){1'b0}}, 1'b1}) : x_den;
    assign myn = syn ? (~y_num + {{(WIDTH-1){1'b0}}, 1'b1}) : y_num;
    assign myd = syd ? (~y_den + {{(WIDTH-1){1'b0}}, 1'b1}) : y_den;

    always_comb
    begin
        a1_next = mxn;
        b1_next = myd;
        s1_next = sxn ^ syd;
        a2_next = '0;
        b2_next = '0;
        s2_next = sxn ^ syd;
        a3_next = mxd;
        b3_next = myd;
        sd_next = sxd ^ syd;
        case (rau_pkg::op_t'(op))
            rau_pkg::OP_ADD, rau_pkg::OP_SUB:
            begin
                a2_next = myn;
                b2_next = mxd;
                s2_next = (syn ^ sxd) ^ (rau_pkg::op_t'(op) == rau_pkg::OP_SUB);
            end
            rau_pkg::OP_MUL:
            begin
                b1_next = myn;
                s1_next = sxn ^ syn;
                s2_next = sxn ^ syn;
            end
            rau_pkg::OP_DIV:
            begin
                b3_next = myn;
                sd_next = sxd ^ syn;
            end
            default:
            begin
                b1_next = {{(WIDTH-1){1'b0}}, 1'b1};
                s1_next = sxn;
                s2_next = sxn;
                b3_next = {{(WIDTH-1){1'b0}}, 1'b1};
                sd_next = sxd;
            end
        endcase
    end

    always_comb
    begin
        if (t1_reg == t2_reg)
        begin
            n3_next = p1_reg + p2_reg;
            sn3     = t1_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            n3_next = p1_reg - p2_reg;
            sn3     = t1_reg;
        end
        else
        begin
            n3_next = p2_reg - p1_reg;
            sn3     = t2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= a1_next;
            b1_reg <= b1_next;
            a2_reg <= a2_next;
            b2_reg <= b2_next;
            a3_reg <= a3_next;
            b3_reg <= b3_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            sd_reg <= sd_next;
            p1_reg <= a1_reg * b1_reg;
            p2_reg <= a2_reg * b2_reg;
            pd_reg <= a3_reg * b3_reg;
            t1_reg <= s1_reg;
            t2_reg <= s2_reg;
            td_reg <= sd_reg;
            n3_reg <= n3_next;
            d3_reg <= pd_reg;
            side3_reg.zero <= (n3_next == '0) || (pd_reg == '0);
            side3_reg.neg  <= sn3 ^ td_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_n     = n3_reg;
    assign out_d     = d3_reg;
    assign out_side  = side3_reg;
endmodule
`default_nettype wire

/* hw/rtl/rau_gcd_stage.sv */
// One registered step of the binary GCD.
`default_nettype none
module rau_gcd_stage #(
    parameter int L  = 64,
    parameter int KW = 7
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_valid,
    input  wire logic [L-1:0]   in_a,
    input  wire logic [L-1:0]   in_b,
    input  wire logic [KW-1:0]  in_k,
    input  wire logic [L-1:0]   in_n,
    input  wire logic [L-1:0]   in_d,
    input  rau_pkg::side_t      in_side,
    output logic                out_valid,
    output logic [L-1:0]        out_a,
    output logic [L-1:0]        out_b,
    output logic [KW-1:0]       out_k,
    output logic [L-1:0]        out_n,
    output logic [L-1:0]        out_d,
    output rau_pkg::side_t      out_side
);
    logic           valid_reg;
    logic [L-1:0]   a_reg, b_reg, n_reg, d_reg;
    logic [KW-1:0]  k_reg;
    rau_pkg::side_t side_reg;
    logic [L-1:0]   a_next, b_next, diff;
    logic [KW-1:0]  k_next;

    always_comb
    begin
        a_next = in_a;
        b_next = in_b;
        k_next = in_k;
        diff   = (in_a >= in_b) ? (in_a - in_b) : (in_b - in_a);
        if (in_a == '0 || in_b == '0)
        begin
            // Finished: hold the pair.
        end
        else if (!in_a[0] && !in_b[0])
        begin
            a_next = in_a >> 1;
            b_next = in_b >> 1;
            k_next = in_k + {{(KW-1){1'b0}}, 1'b1};
        end
        else if (!in_a[0])
        begin
            a_next = in_a >> 1;
        end
        else if (!in_b[0])
        begin
            b_next = in_b >> 1;
        end
        else if (in_a >= in_b)
        begin
            a_next = diff >> 1;
        end
        else
        begin
            b_next = diff >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            k_reg    <= k_next;
            n_reg    <= in_n;
            d_reg    <= in_d;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_k     = k_reg;
    assign out_n     = n_reg;
    assign out_d     = d_reg;
    assign out_side  = side_reg;
endmodule
`default_nettype wire

/* hw/rtl/rau_div_stage.sv */
// One registered restoring-division step for numerator and denominator by the GCD.
`default_nettype none
module rau_div_stage #(
    parameter int L = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_valid,
    input  wire logic [L-1:0]   in_g,
    input  wire logic [L-1:0]   in_rn,
    input  wire logic [L-1:0]   in_qn,
    input  wire logic [L-1:0]   in_rd,
    input  wire logic [L-1:0]   in_qd,
    input  rau_pkg::side_t      in_side,
    output logic                out_valid,
    output logic [L-1:0]        out_g,
    output logic [L-1:0]        out_rn,
    output logic [L-1:0]        out_qn,
    output logic [L-1:0]        out_rd,
    output logic [L-1:0]        out_qd,
    output rau_pkg::side_t      out_side
);
    // q vectors shift the dividend out at the top and quotient bits in at the bottom.
    logic           valid_reg;
    logic [L-1:0]   g_reg, rn_reg, qn_reg, rd_reg, qd_reg;
    rau_pkg::side_t side_reg;
    logic [L:0]     tn, td, sub_n, sub_d;
    logic           gen, ged;

    assign tn    = {in_rn, in_qn[L-1]};
    assign td    = {in_rd, in_qd[L-1]};
    assign sub_n = tn - {1'b0, in_g};
    assign sub_d = td - {1'b0, in_g};
    assign gen   = tn >= {1'b0, in_g};
    assign ged   = td >= {1'b0, in_g};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_reg    <= in_g;
            rn_reg   <= gen ? sub_n[L-1:0] : tn[L-1:0];
            rd_reg   <= ged ? sub_d[L-1:0] : td[L-1:0];
            qn_reg   <= {in_qn[L-2:0], gen};
            qd_reg   <= {in_qd[L-2:0], ged};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_g     = g_reg;
    assign out_rn    = rn_reg;
    assign out_qn    = qn_reg;
    assign out_rd    = rd_reg;
    assign out_qd    = qd_reg;
    assign out_side  = side_reg;
endmodule
`default_nettype wire

/* hw/rtl/rational_arith_unit.sv */
// Top level of the rational arithmetic unit: a fully pipelined fraction calculator.
// Usage: an input transaction carries the operation code in s_tuser and the two
// fractions in s_tdata; each accepted transaction yields exactly one output
// transaction with the reduced fraction in m_tdata and the overflow flag in m_tuser.
// The pipeline takes three front stages (operand split, cross products, numerator
// sum), 4*WIDTH binary-GCD steps, one stage forming the GCD, 2*WIDTH restoring
// division steps and one output register, one step per stage. A new transaction
// can be accepted in every cycle as long as no result is stuck in the output register.
// The whole pipeline advances together: when the output register holds a result
// that the receiver does not take, every stage stops and s_tready falls, so
// nothing is lost or repeated. Reset clears all valid bits; data registers are
// not reset. Only the low WIDTH bits of each input field are used.
`default_nettype none
module rational_arith_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // x_num[31:0], x_den[63:32], y_num[95:64], y_den[127:96]
    input  wire logic [2:0]   s_tuser,   // op[2:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // res_num[31:0], res_den[62:32], zero pad[63]
    output logic [0:0]        m_tuser    // overflow[0]
);
    localparam int L     = 2 * WIDTH;
    localparam int KW    = $clog2(L + 1);
    localparam int NGCD  = 4 * WIDTH;
    localparam int NDIV  = L;
    localparam logic [L-1:0] HALF = {{(L-1){1'b0}}, 1'b1} << (WIDTH - 1);

    logic adv;

    // Global advance: everything moves unless a result is stuck at the output.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Front end
    logic           f_valid;
    logic [L-1:0]   f_n, f_d;
    rau_pkg::side_t f_side;

    rau_front #(.WIDTH(WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .op        (s_tuser),
        .x_num     (s_tdata[WIDTH-1:0]),
        .x_den     (s_tdata[32+WIDTH-1:32]),
        .y_num     (s_tdata[64+WIDTH-1:64]),
        .y_den     (s_tdata[96+WIDTH-1:96]),
        .out_valid (f_valid),
        .out_n     (f_n),
        .out_d     (f_d),
        .out_side  (f_side)
    );

    // Binary GCD chain; the pair starts as the numerator and denominator magnitudes.
    logic           gv   [NGCD+1];
    logic [L-1:0]   ga   [NGCD+1];
    logic [L-1:0]   gb   [NGCD+1];
    logic [KW-1:0]  gk   [NGCD+1];
    logic [L-1:0]   gn   [NGCD+1];
    logic [L-1:0]   gd   [NGCD+1];
    rau_pkg::side_t gs   [NGCD+1];

    assign gv[0] = f_valid;
    assign ga[0] = f_n;
    assign gb[0] = f_d;
    assign gk[0] = '0;
    assign gn[0] = f_n;
    assign gd[0] = f_d;
    assign gs[0] = f_side;

    for (genvar i = 0; i < NGCD; i++)
    begin : g_gcd
        rau_gcd_stage #(.L(L), .KW(KW)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (gv[i]),
            .in_a      (ga[i]),
            .in_b      (gb[i]),
            .in_k      (gk[i]),
            .in_n      (gn[i]),
            .in_d      (gd[i]),
            .in_side   (gs[i]),
            .out_valid (gv[i+1]),
            .out_a     (ga[i+1]),
            .out_b     (gb[i+1]),
            .out_k     (gk[i+1]),
            .out_n     (gn[i+1]),
            .out_d     (gd[i+1]),
            .out_side  (gs[i+1])
        );
    end

    // GCD formation: the odd remainder shifted back by the common power of two.
    logic           gf_valid_reg;
    logic [L-1:0]   gf_g_reg, gf_n_reg, gf_d_reg;
    rau_pkg::side_t gf_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gf_valid_reg <= 1'b0;
        else if (adv)
            gf_valid_reg <= gv[NGCD];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gf_g_reg    <= (ga[NGCD] | gb[NGCD]) << gk[NGCD];
            gf_n_reg    <= gn[NGCD];
            gf_d_reg    <= gd[NGCD];
            gf_side_reg <= gs[NGCD];
        end
    end

    // Division chain: both magnitudes divided by the GCD side by side.
    logic           dv   [NDIV+1];
    logic [L-1:0]   dg   [NDIV+1];
    logic [L-1:0]   drn  [NDIV+1];
    logic [L-1:0]   dqn  [NDIV+1];
    logic [L-1:0]   drd  [NDIV+1];
    logic [L-1:0]   dqd  [NDIV+1];
    rau_pkg::side_t ds   [NDIV+1];

    assign dv[0]  = gf_valid_reg;
    assign dg[0]  = gf_g_reg;
    assign drn[0] = '0;
    assign dqn[0] = gf_n_reg;
    assign drd[0] = '0;
    assign dqd[0] = gf_d_reg;
    assign ds[0]  = gf_side_reg;

    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        rau_div_stage #(.L(L)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv[j]),
            .in_g      (dg[j]),
            .in_rn     (drn[j]),
            .in_qn     (dqn[j]),
            .in_rd     (drd[j]),
            .in_qd     (dqd[j]),
            .in_side   (ds[j]),
            .out_valid (dv[j+1]),
            .out_g     (dg[j+1]),
            .out_rn    (drn[j+1]),
            .out_qn    (dqn[j+1]),
            .out_rd    (drd[j+1]),
            .out_qd    (dqd[j+1]),
            .out_side  (ds[j+1])
        );
    end

    // Output stage: sign, range check and truncation to the field widths.
    logic                    neg;
    logic [L-1:0]            qn, qd, sv;
    logic                    ovf_next;
    logic signed [WIDTH-1:0] num_w;
    logic                    valid_reg;
    logic [31:0]             res_num_reg;
    logic [30:0]             res_den_reg;
    logic                    ovf_reg;

    always_comb
    begin
        if (ds[NDIV].zero)
        begin
            neg = 1'b0;
            qn  = '0;
            qd  = {{(L-1){1'b0}}, 1'b1};
        end
        else
        begin
            neg = ds[NDIV].neg;
            qn  = dqn[NDIV];
            qd  = dqd[NDIV];
        end
        ovf_next = (neg ? (qn > HALF) : (qn > HALF - {{(L-1){1'b0}}, 1'b1}))
                   || (qd > HALF - {{(L-1){1'b0}}, 1'b1});
        sv       = neg ? (~qn + {{(L-1){1'b0}}, 1'b1}) : qn;
        num_w    = sv[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= dv[NDIV];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_num_reg <= 32'(num_w);
            res_den_reg <= 31'(qd[WIDTH-2:0]);
            ovf_reg     <= ovf_next;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = {1'b0, res_den_reg, res_num_reg};
    assign m_tuser[0] = ovf_reg;

    // A result inside the range always has a non-zero denominator.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[62:32] != 31'd0)
        else $error("in-range result with zero denominator");

    // A zero numerator that is in range is always written as 0/1.
    a_zero_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && m_tdata[31:0] == 32'd0 |-> m_tdata[62:32] == 31'd1)
        else $error("zero result not normalised to 0/1");

    // The GCD handed to the dividers is never zero for a non-trivial item.
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gf_valid_reg && !gf_side_reg.zero |-> gf_g_reg != '0)
        else $error("zero divisor entering the division chain");

    // A stalled output holds back the input side in the same cycle.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> !$past(s_tready) && $stable(valid_reg))
        else $error("pipeline moved while the output was stalled");
endmodule
`default_nettype wire

/* dv/tb_rational_arith_unit.sv */
// Self-checking testbench for the rational arithmetic unit, with a scoreboard class and stream drivers.
`timescale 1ns / 100ps
module tb_rational_arith_unit;

    localparam int WIDTH = 32;
    localparam int LATENCY = 6 * WIDTH + 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [63:0] WMASK = (64'd1 << WIDTH) - 64'd1;
    localparam logic [63:0] HALF = 64'd1 << (WIDTH - 1);

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        ovf;
    } fraction_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int phase = 0;
    bit rx_hold = 0;
    int cycles = 0;
    int overflow_seen = 0;

    rational_arith_unit #(.WIDTH(WIDTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Splits a WIDTH-bit two's complement field into sign and magnitude.
    function automatic void split_signed(input logic [31:0] raw, output bit neg,
                                         output logic [63:0] mag);
        logic [63:0] v;
        v = {32'd0, raw} & WMASK;
        neg = v[WIDTH-1];
        mag = neg ? ((~v + 64'd1) & WMASK) : v;
        if (neg && mag == 0)
            mag = HALF;
    endfunction

    // Exact fraction arithmetic followed by reduction by the Euclidean GCD.
    function automatic fraction_t compute_reduced_fraction(input logic [2:0] op,
                                                           input logic [127:0] operands);
        bit sxn, sxd, syn, syd, sn, sd, s1, s2, neg;
        logic [63:0] mxn, mxd, myn, myd, mn, md, p1, p2, a, b, t, qn, qd, sv;
        fraction_t r;
        split_signed(operands[31:0], sxn, mxn);
        split_signed(operands[63:32], sxd, mxd);
        split_signed(operands[95:64], syn, myn);
        split_signed(operands[127:96], syd, myd);
        if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB)
        begin
            s1 = sxn != syd;
            p1 = mxn * myd;
            s2 = (syn != sxd) != (op == rau_pkg::OP_SUB);
            p2 = myn * mxd;
            if (s1 == s2)
            begin
                sn = s1;
                mn = p1 + p2;
            end
            else if (p1 >= p2)
            begin
                sn = s1;
                mn = p1 - p2;
            end
            else
            begin
                sn = s2;
                mn = p2 - p1;
            end
            sd = sxd != syd;
            md = mxd * myd;
        end
        else if (op == rau_pkg::OP_MUL)
        begin
            sn = sxn != syn;
            mn = mxn * myn;
            sd = sxd != syd;
            md = mxd * myd;
        end
        else if (op == rau_pkg::OP_DIV)
        begin
            // Dividing by a zero fraction collapses to 0/1.
            sn = sxn != syd;
            mn = (myn == 0) ? 64'd0 : mxn * myd;
            sd = sxd != syn;
            md = (myn == 0) ? 64'd1 : mxd * myn;
        end
        else
        begin
            // Reduce, and the unused codes behave the same way.
            sn = sxn;
            mn = mxn;
            sd = sxd;
            md = mxd;
        end
        if (md == 0 || mn == 0)
        begin
            neg = 0;
            qn = 0;
            qd = 1;
        end
        else
        begin
            a = mn;
            b = md;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            neg = sn != sd;
            qn = mn / a;
            qd = md / a;
        end
        r.ovf = (neg ? (qn > HALF) : (qn > HALF - 64'd1)) || (qd > HALF - 64'd1);
        sv = (neg ? (~qn + 64'd1) : qn) & WMASK;
        if (sv[WIDTH-1])
            sv = sv | ~WMASK;
        r.num = sv[31:0];
        r.den = 31'(qd & (HALF - 64'd1));
        return r;
    endfunction

    class fraction_scoreboard;
        fraction_t pending_results[$];
        int failures = 0;
        int checked = 0;

        function void note_request(logic [2:0] op, logic [127:0] operands);
            pending_results.push_back(compute_reduced_fraction(op, operands));
        endfunction

        function void check_result(logic [31:0] num, logic [30:0] den, logic ovf);
            fraction_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding: num=%0h den=%0h", num, den);
                failures++;
                return;
            end
            exp_r = pending_results.pop_front();
            checked++;
            if (num !== exp_r.num)
            begin
                $error("res_num expected %0h actual %0h", exp_r.num, num);
                failures++;
            end
            if (den !== exp_r.den)
            begin
                $error("res_den expected %0h actual %0h", exp_r.den, den);
                failures++;
            end
            if (ovf !== exp_r.ovf)
            begin
                $error("overflow expected %0b actual %0b", exp_r.ovf, ovf);
                failures++;
            end
        endfunction
    endclass

    fraction_scoreboard fraction_sb = new();

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Results are taken at the edge where both handshake signals are high.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            fraction_sb.check_result(m_tdata[31:0], m_tdata[62:32], m_tuser[0]);
            if (m_tuser[0])
                overflow_seen++;
        end
    end

    // Receiver: random back-pressure, or a long hold while rx_hold is set.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // The long hold during the last phase lets the pipeline fill and stall its input.
    initial
    begin
        wait (phase == 3);
        repeat (100) @(posedge clk);
        rx_hold = 1;
        repeat (600) @(posedge clk);
        rx_hold = 0;
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rational_arith_unit test failed");
            $finish;
        end
    end

    task automatic send_transaction(input logic [2:0] op, input logic [31:0] xn,
                                    input logic [31:0] xd, input logic [31:0] yn,
                                    input logic [31:0] yd);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {yd, yn, xd, xn};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        fraction_sb.note_request(op, {yd, yn, xd, xn});
    endtask

    // Mostly small values so that reductions happen, plus edges and full random words.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom();
            2:       v = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
            3:       v = 32'($signed($urandom_range(0, 2)) - 1);
            4:       v = 32'($urandom_range(0, 4000) * $urandom_range(1, 60000));
            default: v = 32'($signed($urandom_range(0, 60)) - 30);
        endcase
        return v;
    endfunction

    task automatic run_random(input int count);
        logic [2:0] op;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                op = 3'($urandom_range(5, 7));
            else
                op = rau_pkg::op_t'($urandom_range(0, 4));
            send_transaction(op, pick_value(), pick_value(), pick_value(), pick_value());
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = rau_pkg::OP_ADD;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: each operation, zero denominators, zero numerators, extremes.
        send_transaction(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_transaction(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_transaction(rau_pkg::OP_SUB, 32'd1, 32'd3, 32'd1, 32'd2);
        send_transaction(rau_pkg::OP_MUL, 32'd6, -32'sd4, 32'd2, 32'd9);
        send_transaction(rau_pkg::OP_DIV, -32'sd3, 32'd4, 32'd9, -32'sd8);
        send_transaction(rau_pkg::OP_RED, 32'd6, -32'sd4, 32'd0, 32'd0);
        send_transaction(rau_pkg::OP_ADD, 32'd5, 32'd0, 32'd1, 32'd2);
        send_transaction(rau_pkg::OP_MUL, 32'd5, 32'd7, 32'd1, 32'd0);
        send_transaction(rau_pkg::OP_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
        send_transaction(rau_pkg::OP_RED, 32'd0, -32'sd9, 32'd1, 32'd1);
        send_transaction(3'd5, 32'd10, 32'd4, 32'd1, 32'd1);
        send_transaction(3'd6, -32'sd10, -32'sd4, 32'd1, 32'd1);
        send_transaction(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_transaction(rau_pkg::OP_RED, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
        send_transaction(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
        send_transaction(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_transaction(rau_pkg::OP_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 32'd2);
        send_transaction(rau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h8000_0000);
        send_transaction(rau_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000,
                         32'h8000_0000, 32'h7fff_ffff);
        send_transaction(rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000);

        phase = 1;
        tx_idle_pct = 18;
        rx_idle_pct = 85;
        run_random(245);
        phase = 2;
        tx_idle_pct = 85;
        rx_idle_pct = 18;
        run_random(245);
        phase = 3;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(260);
        s_tvalid <= 1'b0;

        waited = 0;
        while (fraction_sb.pending_results.size() != 0 && waited < 20 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 20) @(posedge clk);

        $display("Checked %0d results across add, subtract, multiply, divide and reduce,",
                 fraction_sb.checked);
        $display("with %0d overflowing results and three phases of back-pressure.",
                 overflow_seen);
        if (fraction_sb.failures == 0 && fraction_sb.pending_results.size() == 0)
            $display("rational_arith_unit test passed");
        else
            $display("rational_arith_unit test failed");
        $finish;
    end
endmodule
